// ===== design/lcpd_pkg.sv =====
// shared constants and types for the lehmer code permutation decoder
package lcpd_pkg;

    localparam int MAX_LENGTH_DEF = 64;
    localparam int MIN_LENGTH     = 2;
    localparam int ELEM_W         = 7;
    localparam int DIGIT_W        = 6;
    localparam int LEN_W          = 7;
    localparam int ADDR_W_MAX     = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W_MAX-1:0] wr_addr;
        logic [ELEM_W-1:0]     wr_data;
        logic                  rd_en;
        logic [ADDR_W_MAX-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== design/lcpd_store.sv =====
// element store: one write port, one read port with registered read data
module lcpd_store #(
    parameter int MAX_LENGTH = lcpd_pkg::MAX_LENGTH_DEF
) (
    input  logic                        clk,
    input  lcpd_pkg::mem_req_t          mem_req,
    output logic [lcpd_pkg::ELEM_W-1:0] rd_data
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    logic [lcpd_pkg::ELEM_W-1:0] mem [MAX_LENGTH];
    logic [lcpd_pkg::ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lcpd_seq.sv =====
// sequencer: digit loading, in-place decode over the store, and element output
module lcpd_seq #(
    parameter int MAX_LENGTH = lcpd_pkg::MAX_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]      n_len,
    input  logic                                 cfg_wr_en,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lcpd_pkg::DIGIT_W-1:0]         code_digit,
    output lcpd_pkg::mem_req_t                   mem_req,
    input  logic [lcpd_pkg::ELEM_W-1:0]          mem_rdata,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lcpd_pkg::ELEM_W-1:0]          perm_element,
    output logic                                 last_element
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW = $clog2(MAX_LENGTH+1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FIRST,
        ST_INNER,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [AW-1:0]               load_count_reg, load_count_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               wb_reg, wb_next;
    logic [lcpd_pkg::ELEM_W-1:0] cur_reg, cur_next;
    logic [CW-1:0]               emit_idx_reg, emit_idx_next;
    logic                        pend_reg, pend_next;
    logic                        pend_last_reg, pend_last_next;
    logic                        out_valid_reg, out_valid_next;
    logic [lcpd_pkg::ELEM_W-1:0] out_elem_reg, out_elem_next;
    logic                        out_last_reg, out_last_next;

    logic [CW-1:0]               n_m1;
    logic [AW-1:0]               last_addr;
    logic                        in_acc;
    logic                        move;
    logic                        issue;
    lcpd_pkg::mem_req_t          req;

    assign n_m1      = n_len - CW'(1);
    assign last_addr = n_m1[AW-1:0];
    assign in_acc    = in_valid && (state_reg == ST_LOAD);
    assign move      = pend_reg && (!out_valid_reg || !out_stall);
    assign issue     = (state_reg == ST_EMIT) && (emit_idx_reg < n_len) && (!pend_reg || move);

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        pos_next        = pos_reg;
        wb_next         = wb_reg;
        cur_next        = cur_reg;
        emit_idx_next   = emit_idx_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        req             = '0;

        if (move)
        begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    req.wr_en = 1'b1;
                    if (load_count_reg == last_addr)
                    begin
                        // final digit is forced to zero, start with position n-2
                        req.wr_addr     = lcpd_pkg::ADDR_W_MAX'(last_addr);
                        req.wr_data     = '0;
                        req.rd_en       = 1'b1;
                        req.rd_addr     = lcpd_pkg::ADDR_W_MAX'(last_addr - AW'(1));
                        pos_next        = last_addr - AW'(1);
                        load_count_next = '0;
                        state_next      = ST_FIRST;
                    end
                    else
                    begin
                        req.wr_addr     = lcpd_pkg::ADDR_W_MAX'(load_count_reg);
                        req.wr_data     = lcpd_pkg::ELEM_W'(code_digit);
                        load_count_next = load_count_reg + AW'(1);
                    end
                end
            end
            ST_FIRST:
            begin
                cur_next    = mem_rdata;
                req.rd_en   = 1'b1;
                req.rd_addr = lcpd_pkg::ADDR_W_MAX'(pos_reg + AW'(1));
                wb_next     = pos_reg + AW'(1);
                state_next  = ST_INNER;
            end
            ST_INNER:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = lcpd_pkg::ADDR_W_MAX'(wb_reg);
                req.wr_data = (mem_rdata >= cur_reg) ? mem_rdata + lcpd_pkg::ELEM_W'(1)
                                                     : mem_rdata;
                if (wb_reg == last_addr)
                begin
                    if (pos_reg == '0)
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = lcpd_pkg::ADDR_W_MAX'(pos_reg - AW'(1));
                        pos_next    = pos_reg - AW'(1);
                        state_next  = ST_FIRST;
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = lcpd_pkg::ADDR_W_MAX'(wb_reg + AW'(1));
                    wb_next     = wb_reg + AW'(1);
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    req.rd_en      = 1'b1;
                    req.rd_addr    = lcpd_pkg::ADDR_W_MAX'(emit_idx_reg[AW-1:0]);
                    emit_idx_next  = emit_idx_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (emit_idx_reg == n_m1);
                end
                if (move && pend_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (move)
        begin
            out_valid_next = 1'b1;
            out_elem_next  = mem_rdata;
            out_last_next  = pend_last_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            load_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            pos_reg        <= '0;
            wb_reg         <= '0;
            cur_reg        <= '0;
            emit_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_elem_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            pos_reg        <= pos_next;
            wb_reg         <= wb_next;
            cur_reg        <= cur_next;
            emit_idx_reg   <= emit_idx_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            out_elem_reg   <= out_elem_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign mem_req      = req;
    assign in_stall     = (state_reg != ST_LOAD);
    assign out_valid    = out_valid_reg;
    assign perm_element = out_elem_reg;
    assign last_element = out_last_reg;

`ifndef SYNTHESIS
    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
        else $error("store read and write hit the same entry");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_EMIT))
        else $error("pending element outside output phase");

    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pend_reg))
        else $error("output became valid without a pending element");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emit_idx_reg <= n_len))
        else $error("output index ran past the length");
`endif

endmodule

// ===== design/lehmer_code_permutation_decoder.sv =====
// top level of the lehmer code permutation decoder
//
// input channel: one code digit per transfer (in_valid / in_stall). after n
// digits the block decodes them in place and emits n elements on the output
// channel (out_valid / out_stall), last_element marking the final one.
// the last digit of each group is replaced by zero.
// perm_length is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while idle, the block does not enforce it. a write drops any partly
// loaded digits. values below 2 act as 2, above MAX_LENGTH as MAX_LENGTH.
// decode: after the last digit the block walks the store with one read and
// one write port: for each position from n-2 down to 0 it reads the digit,
// then reads and rewrites every later element, adding one where it is not
// below the digit. output then runs one element per cycle while not stalled.
// in_stall is high from the last digit until the final element enters the
// output register. a stalled output holds its element; the next store read
// waits in the read data register.
// reset: length 64, no digits held, output empty; store contents undefined.
module lehmer_code_permutation_decoder #(
    parameter int MAX_LENGTH = lcpd_pkg::MAX_LENGTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lcpd_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lcpd_pkg::DIGIT_W-1:0]  code_digit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lcpd_pkg::ELEM_W-1:0]   perm_element,
    output logic                          last_element
);

    localparam int CW = $clog2(MAX_LENGTH+1);

    logic [lcpd_pkg::LEN_W-1:0]  perm_length_reg;
    logic [CW-1:0]               n_len;
    lcpd_pkg::mem_req_t          mem_req;
    logic [lcpd_pkg::ELEM_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_length_reg <= lcpd_pkg::LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            perm_length_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (perm_length_reg < lcpd_pkg::LEN_W'(lcpd_pkg::MIN_LENGTH))
        begin
            n_len = CW'(lcpd_pkg::MIN_LENGTH);
        end
        else if (perm_length_reg > lcpd_pkg::LEN_W'(MAX_LENGTH))
        begin
            n_len = CW'(MAX_LENGTH);
        end
        else
        begin
            n_len = perm_length_reg[CW-1:0];
        end
    end

    lcpd_store #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (mem_rdata)
    );

    lcpd_seq #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_len        (n_len),
        .cfg_wr_en    (cfg_wr_en),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_digit   (code_digit),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .perm_element (perm_element),
        .last_element (last_element)
    );

endmodule
